FILE: sv/ispd_pkg.sv
// ----------------------------------------------------------------------------
// ispd_pkg
// Shared types and constants for the serial packet deframer.
// ----------------------------------------------------------------------------
package ispd_pkg;

  localparam int unsigned PAYLOAD_LEN = 8;
  localparam int unsigned CNT_W       = $clog2(PAYLOAD_LEN);
  localparam int unsigned PADDR_W     = 3;

  localparam logic [7:0] START_BYTE_RST = 8'h55;

  // register index (paddr word index)
  localparam logic REG_START_BYTE = 1'b0;

  typedef struct packed {
    logic [7:0]         message_id;
    logic signed [15:0] word_zero;
    logic signed [15:0] word_one;
    logic signed [15:0] word_two;
    logic signed [15:0] word_three;
  } ispd_result_t;

endpackage

FILE: sv/imu_serial_packet_deframer_top.sv
// A good frame's result is registered on its checksum transfer, into skid_q if out_q is held.
// Throughput: one byte per cycle unless in_stall_o; parser state registers take each transfer.
// in_stall_o rises only while a result waits in the skid register behind a stalled output.
// Reset (rst_ni low, asynchronous): parser hunts for the start byte, output empty,
// start_byte returns to 0x55. Payload store is not reset.
// ----------------------------------------------------------------------------
// imu_serial_packet_deframer_top
// Byte-stream deframer with start byte, id, eight payload bytes and checksum.
// ----------------------------------------------------------------------------
module imu_serial_packet_deframer_top import ispd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          message_id_o,
  output logic signed [15:0]  word_zero_o,
  output logic signed [15:0]  word_one_o,
  output logic signed [15:0]  word_two_o,
  output logic signed [15:0]  word_three_o
);

  logic [7:0]   start_byte_q;
  logic         in_fire;
  logic         res_valid;
  ispd_result_t res;
  logic         out_valid_q, skid_valid_q;
  ispd_result_t out_q, skid_q;
  logic         pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_START_BYTE) ? {24'd0, start_byte_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= START_BYTE_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_START_BYTE)) begin
      start_byte_q <= pwdata[7:0];
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !in_stall_o;

  ispd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_byte_i   (start_byte_q),
    .byte_valid_i   (in_fire),
    .byte_i         (rx_byte_i),
    .result_valid_o (res_valid),
    .result_o       (res)
  );

  assign pop = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      if (out_valid_q && !pop) skid_valid_q <= 1'b1;
      else out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) out_q <= skid_q;
    end else if (res_valid) begin
      if (out_valid_q && !pop) skid_q <= res;
      else out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign message_id_o = out_q.message_id;
  assign word_zero_o  = out_q.word_zero;
  assign word_one_o   = out_q.word_one;
  assign word_two_o   = out_q.word_two;
  assign word_three_o = out_q.word_three;

endmodule

FILE: sv/ispd_parser.sv
// ----------------------------------------------------------------------------
// ispd_parser
// Frame hunt, payload capture and additive checksum check; one byte a cycle.
// ----------------------------------------------------------------------------
module ispd_parser import ispd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [7:0]   start_byte_i,
  input  logic         byte_valid_i,
  input  logic [7:0]   byte_i,
  output logic         result_valid_o,
  output ispd_result_t result_o
);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_ID   = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       id_q, id_d;
  logic [7:0]       store_q [PAYLOAD_LEN];
  logic             store_we;

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    sum_d    = sum_q;
    id_d     = id_q;
    store_we = 1'b0;
    result_valid_o = 1'b0;
    if (byte_valid_i) begin
      case (phase_q)
        PH_HUNT: begin
          sum_d = byte_i;
          if (byte_i == start_byte_i) phase_d = PH_ID;
        end
        PH_ID: begin
          id_d    = byte_i;
          sum_d   = sum_q + byte_i;
          count_d = '0;
          phase_d = PH_DATA;
        end
        PH_DATA: begin
          store_we = 1'b1;
          sum_d    = sum_q + byte_i;
          if (count_q == CNT_LAST) begin
            count_d = '0;
            phase_d = PH_SUM;
          end else begin
            count_d = count_q + CNT_ONE;
          end
        end
        PH_SUM: begin
          phase_d        = PH_HUNT;
          result_valid_o = (byte_i == sum_q);
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  assign result_o.message_id = id_q;
  assign result_o.word_zero  = {store_q[1], store_q[0]};
  assign result_o.word_one   = {store_q[3], store_q[2]};
  assign result_o.word_two   = {store_q[5], store_q[4]};
  assign result_o.word_three = {store_q[7], store_q[6]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
      sum_q   <= '0;
      id_q    <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      id_q    <= id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) store_q[count_q] <= byte_i;
  end

  a_result_in_sum_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (phase_q == PH_SUM))
    else $error("result outside checksum phase");

  a_count_clear_outside_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_DATA) |-> (count_q == '0))
    else $error("payload count not cleared");

  a_data_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA && count_q != '0) |-> $past(phase_q == PH_DATA))
    else $error("payload count advanced outside data phase");

  a_sum_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (byte_valid_i && phase_q == PH_DATA && count_q == CNT_LAST) |=> (phase_q == PH_SUM))
    else $error("missed checksum phase");

endmodule

FILE: tb/sv/imu_serial_packet_deframer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_serial_packet_deframer_top_tb
// Drives byte transfers into the deframer and checks every decoded frame
// against a cycle-free frame predictor. Directed frames cover word extremes,
// start-byte values inside a frame and a bad checksum. Random traffic is mostly
// well-formed frames with some bad checksums, truncated frames and noise. The
// start byte register is rewritten between phases, and one write goes to an
// unmapped address. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module imu_serial_packet_deframer_top_tb import ispd_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BYTES = 240;

  typedef enum logic [1:0] {PH_HUNT, PH_ID, PH_DATA, PH_CSUM} parse_e;

  class frame_scoreboard;
    logic [7:0]   start_val;
    parse_e       phase;
    int unsigned  taken;
    logic [7:0]   csum;
    logic [7:0]   id_hold;
    logic [7:0]   payload [PAYLOAD_LEN];
    ispd_result_t pending [$];
    int unsigned  mismatches;

    function new();
      start_val  = START_BYTE_RST;
      phase      = PH_HUNT;
      taken      = 0;
      csum       = 8'h00;
      id_hold    = 8'h00;
      mismatches = 0;
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void write_reg(int unsigned idx, logic [31:0] value);
      if (idx == REG_START_BYTE) start_val = value[7:0];
    endfunction

    // accepted byte transfer
    function void take_byte(logic [7:0] b);
      ispd_result_t frame;
      case (phase)
        PH_HUNT: begin
          csum = b;
          if (b == start_val) phase = PH_ID;
        end
        PH_ID: begin
          id_hold = b;
          csum    = csum + b;
          taken   = 0;
          phase   = PH_DATA;
        end
        PH_DATA: begin
          payload[taken] = b;
          csum = csum + b;
          if (taken == PAYLOAD_LEN - 1) begin
            taken = 0;
            phase = PH_CSUM;
          end else begin
            taken++;
          end
        end
        default: begin
          phase = PH_HUNT;
          if (b == csum) begin
            frame.message_id = id_hold;
            frame.word_zero  = {payload[1], payload[0]};
            frame.word_one   = {payload[3], payload[2]};
            frame.word_two   = {payload[5], payload[4]};
            frame.word_three = {payload[7], payload[6]};
            pending.push_back(frame);
          end
        end
      endcase
    endfunction

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    // accepted result transfer
    task check_frame(ispd_result_t got);
      ispd_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected frame, id %h", got.message_id));
        return;
      end
      want = pending.pop_front();
      check_field("message_id", {8'h00, got.message_id}, {8'h00, want.message_id});
      check_field("word_zero", got.word_zero, want.word_zero);
      check_field("word_one", got.word_one, want.word_one);
      check_field("word_two", got.word_two, want.word_two);
      check_field("word_three", got.word_three, want.word_three);
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          rx_byte_i = 8'h00;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          message_id_o;
  logic signed [15:0]  word_zero_o;
  logic signed [15:0]  word_one_o;
  logic signed [15:0]  word_two_o;
  logic signed [15:0]  word_three_o;

  frame_scoreboard sb = new();
  int unsigned     cycles = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     stall_left = 0;

  imu_serial_packet_deframer_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .message_id_o (message_id_o),
    .word_zero_o  (word_zero_o),
    .word_one_o   (word_one_o),
    .word_two_o   (word_two_o),
    .word_three_o (word_three_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("imu_serial_packet_deframer_top regression: fail");
      $finish;
    end
  end

  // output stall: ~12% of cycles, none in a long quiet window
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (!(cycles >= 3000 && cycles < 6000) && $urandom_range(0, 99) < 4) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    ispd_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.message_id = message_id_o;
      got.word_zero  = word_zero_o;
      got.word_one   = word_one_o;
      got.word_two   = word_two_o;
      got.word_three = word_three_o;
      sb.check_frame(got);
    end
  end

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.write_reg(addr >> 2, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic put_byte(logic [7:0] b);
    if (!(bytes_sent >= 400 && bytes_sent < 650) && $urandom_range(0, 99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) return sb.start_val;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_frame(logic [7:0] id, logic [63:0] data, bit corrupt);
    logic [7:0] sum;
    sum = sb.start_val + id;
    put_byte(sb.start_val);
    put_byte(id);
    for (int k = 0; k < PAYLOAD_LEN; k++) begin
      put_byte(data[8*k +: 8]);
      sum = sum + data[8*k +: 8];
    end
    put_byte(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned sent;
    int unsigned r;
    int unsigned cut;
    logic [63:0] data;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      for (int k = 0; k < PAYLOAD_LEN; k++) data[8*k +: 8] = rand_byte();
      if (r < 80) begin
        send_frame(rand_byte(), data, 1'b0);
        sent += 11;
      end else if (r < 90) begin
        send_frame(rand_byte(), data, 1'b1);
        sent += 11;
      end else if (r < 95) begin
        // truncated frame, the stream realigns on its own
        cut = $urandom_range(0, 9);
        put_byte(sb.start_val);
        repeat (cut) put_byte(rand_byte());
        sent += cut + 1;
      end else begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // sender holds off until every decoded frame has come out
  task automatic wait_for_frames();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put_byte(8'h00);
    put_byte(8'hFF);
    send_frame(8'hFF, 64'hFFFF_0000_7FFF_8000, 1'b0);
    send_frame(START_BYTE_RST, {56'h07_0605_0403_0201, START_BYTE_RST}, 1'b1);
    random_traffic(PHASE_BYTES);
    wait_for_frames();

    apb_write(PADDR_W'(REG_START_BYTE) << 2, {24'($urandom()), 8'h00});
    random_traffic(PHASE_BYTES);
    wait_for_frames();

    apb_write(PADDR_W'(REG_START_BYTE) << 2, {24'($urandom()), 8'hFF});
    random_traffic(PHASE_BYTES);
    wait_for_frames();

    apb_write(PADDR_W'(REG_START_BYTE) << 2, $urandom());
    random_traffic(PHASE_BYTES);
    wait_for_frames();

    // unmapped register, must not move the start byte
    apb_write(PADDR_W'(4), $urandom());
    random_traffic(PHASE_BYTES);
    wait_for_frames();

    repeat (4) @(posedge clk_i);
    if (sb.pending.size() != 0) sb.report("frames never delivered");
    if (sb.mismatches == 0) begin
      $display("imu_serial_packet_deframer_top regression: pass");
    end else begin
      $display("imu_serial_packet_deframer_top regression: fail");
    end
    $finish;
  end

endmodule
